// ===== hw/rtl/vdhp_pkg.sv =====
// Shared types, constants and helpers of the video display host port.
package vdhp_pkg;

	// Video memory geometry
	localparam int VRAM_DEPTH = 16384;
	localparam int VRAM_AW    = $clog2(VRAM_DEPTH);

	// Field widths of the result word
	localparam int BASE_W  = 14;
	localparam int IMASK_W = 10;

	// Short queues between the parts
	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;
	localparam logic [CFG_IDX_W-1:0] CFG_VRAM_BITS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BITMAP_BIT = 2'd1;
	localparam logic [3:0] VRAM_BITS_RESET = 4'd14;
	localparam logic [3:0] VRAM_BITS_MIN   = 4'd12;
	localparam logic [3:0] VRAM_BITS_MAX   = 4'd14;

	// Control register indexes
	localparam logic [2:0] REG_MODE0    = 3'd0;
	localparam logic [2:0] REG_MODE1    = 3'd1;
	localparam logic [2:0] REG_NAME     = 3'd2;
	localparam logic [2:0] REG_COLOUR   = 3'd3;
	localparam logic [2:0] REG_PATTERN  = 3'd4;
	localparam logic [2:0] REG_SATTR    = 3'd5;
	localparam logic [2:0] REG_SPAT     = 3'd6;
	localparam logic [2:0] REG_BACKDROP = 3'd7;

	// Writable bits of each control register
	localparam logic [7:0] REG_MASK [8] = '{
		8'h03, 8'hfb, 8'h0f, 8'hff, 8'h07, 8'h7f, 8'h07, 8'hff
	};

	// Status byte bits
	localparam logic [7:0] ST_FRAME = 8'h80;
	localparam logic [7:0] ST_KEEP  = 8'h5f;

	// Table base and index mask slots
	localparam int BASE_NAME    = 0;
	localparam int BASE_PATTERN = 1;
	localparam int BASE_COLOUR  = 2;
	localparam int BASE_SATTR   = 3;
	localparam int BASE_SPAT    = 4;
	localparam int NBASES       = 5;
	localparam int MASK_PATTERN = 0;
	localparam int MASK_COLOUR  = 1;
	localparam int NMASKS       = 2;

	// Host access codes on the mode field
	localparam logic [2:0] MODE_MEM_RD = 3'd0;
	localparam logic [2:0] MODE_MEM_WR = 3'd1;
	localparam logic [2:0] MODE_STAT   = 3'd2;
	localparam logic [2:0] MODE_CTRL   = 3'd3;
	localparam logic [2:0] MODE_FRAME  = 3'd4;

	typedef enum logic [2:0] {
		OP_MEM_RD,
		OP_MEM_WR,
		OP_STAT,
		OP_CTRL,
		OP_FRAME,
		OP_NOP
	} op_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_EXEC,
		BK_FIN
	} bk_state_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
	} cmd_t;

	typedef struct packed {
		logic [3:0] vram_bits;
		logic       bitmap_bit;
	} cfg_t;

	typedef struct packed {
		logic clearing;
	} back_stat_t;

	typedef struct packed {
		logic [7:0]         read_data;
		logic               int_line;
		logic [2:0]         display_mode;
		logic               display_enable;
		logic [3:0]         backdrop_colour;
		logic [BASE_W-1:0]  name_base;
		logic [BASE_W-1:0]  pattern_base;
		logic [BASE_W-1:0]  colour_base;
		logic [IMASK_W-1:0] pattern_mask;
		logic [IMASK_W-1:0] colour_mask;
		logic [BASE_W-1:0]  sprite_attr_base;
		logic [BASE_W-1:0]  sprite_pattern_base;
	} result_t;

	// Address mask for the installed memory size, clamped to the legal range
	function automatic logic [BASE_W-1:0] size_mask(input logic [3:0] bits);
		logic [3:0]  b;
		logic [31:0] m;
		b = bits;
		if (b < VRAM_BITS_MIN) b = VRAM_BITS_MIN;
		if (b > VRAM_BITS_MAX) b = VRAM_BITS_MAX;
		m = ((32'd1 << b) - 32'd1) & 32'(VRAM_DEPTH - 1);
		return m[BASE_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/video_display_host_port.sv =====
// Top level of the video display host port.
//
//   channel   direction  handshake           payload
//   input     in         push / full         mode, data_byte
//   result    out        empty / pop         read_data .. sprite_pattern_base
//   config    in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// In the back part each word is first executed in BK_EXEC, which issues the video memory
// read, and then finished in BK_FIN, which lands the read-ahead byte and pushes the result.
// The front queue keeps accepting while the back part works or results wait.
// After reset a clearing pass zeroes all VRAM_DEPTH (16384) bytes of video memory, one byte
// a cycle; full stays high until the pass ends, config is taken as ever.
// A full result queue stalls the back part; the front queue then fills and raises full.
module video_display_host_port import vdhp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [2:0]            mode,
	input  logic [7:0]            data_byte,
	output logic                  empty,
	input  logic                  pop,
	output logic [7:0]            read_data,
	output logic                  int_line,
	output logic [2:0]            display_mode,
	output logic                  display_enable,
	output logic [3:0]            backdrop_colour,
	output logic [BASE_W-1:0]     name_base,
	output logic [BASE_W-1:0]     pattern_base,
	output logic [BASE_W-1:0]     colour_base,
	output logic [IMASK_W-1:0]    pattern_mask,
	output logic [IMASK_W-1:0]    colour_mask,
	output logic [BASE_W-1:0]     sprite_attr_base,
	output logic [BASE_W-1:0]     sprite_pattern_base,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t       cfg_q;
	back_stat_t stat;
	logic       cmd_valid;
	cmd_t       cmd;
	logic       cmd_take;
	logic       res_full;
	logic       res_push;
	result_t    res;
	result_t    head;

	// Take configuration words at any time
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.vram_bits  <= VRAM_BITS_RESET;
			cfg_q.bitmap_bit <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_VRAM_BITS:  cfg_q.vram_bits  <= cfg_data[3:0];
				CFG_BITMAP_BIT: cfg_q.bitmap_bit <= cfg_data[0];
				default: ;
			endcase
		end
	end

	vdhp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.mode      (mode),
		.data_byte (data_byte),
		.hold      (stat.clearing),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take)
	);

	vdhp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res),
		.stat      (stat)
	);

	vdhp_out_queue u_out_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res_in   (res),
		.res_full (res_full),
		.pop      (pop),
		.empty    (empty),
		.res_out  (head)
	);

	// Drive the result ports from the queue head
	assign read_data           = head.read_data;
	assign int_line            = head.int_line;
	assign display_mode        = head.display_mode;
	assign display_enable      = head.display_enable;
	assign backdrop_colour     = head.backdrop_colour;
	assign name_base           = head.name_base;
	assign pattern_base        = head.pattern_base;
	assign colour_base         = head.colour_base;
	assign pattern_mask        = head.pattern_mask;
	assign colour_mask         = head.colour_mask;
	assign sprite_attr_base    = head.sprite_attr_base;
	assign sprite_pattern_base = head.sprite_pattern_base;

endmodule

// ===== hw/rtl/vdhp_front.sv =====
// Front part: accepts host words, classifies them and queues commands.
module vdhp_front import vdhp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [2:0] mode,
	input  logic [7:0] data_byte,
	input  logic       hold,
	output logic       cmd_valid,
	output cmd_t       cmd,
	input  logic       cmd_take
);

	cmd_t              ent_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	cmd_t              cls;
	logic              accept;

	// Classify the access code
	always_comb begin
		cls.data = data_byte;
		case (mode)
			MODE_MEM_RD: cls.op = OP_MEM_RD;
			MODE_MEM_WR: cls.op = OP_MEM_WR;
			MODE_STAT:   cls.op = OP_STAT;
			MODE_CTRL:   cls.op = OP_CTRL;
			MODE_FRAME:  cls.op = OP_FRAME;
			default:     cls.op = OP_NOP;
		endcase
	end

	assign full      = hold || (cnt_q == QCNT_W'(QDEPTH));
	assign accept    = push && !full;
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = ent_q[rd_ptr_q];

	// Store accepted words
	always_ff @(posedge clk) begin
		if (accept) ent_q[wr_ptr_q] <= cls;
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (accept) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (cmd_take) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (accept && !cmd_take) cnt_q <= cnt_q + 1'b1;
			else if (!accept && cmd_take) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== hw/rtl/vdhp_out_queue.sv =====
// Result queue between the back part and the host read side.
module vdhp_out_queue import vdhp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    res_push,
	input  result_t res_in,
	output logic    res_full,
	input  logic    pop,
	output logic    empty,
	output result_t res_out
);

	result_t           ent_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              take;

	assign empty    = (cnt_q == '0);
	assign res_full = (cnt_q == QCNT_W'(QDEPTH));
	assign take     = pop && !empty;
	assign res_out  = ent_q[rd_ptr_q];

	// Store results
	always_ff @(posedge clk) begin
		if (res_push) ent_q[wr_ptr_q] <= res_in;
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (res_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (take) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (res_push && !take) cnt_q <= cnt_q + 1'b1;
			else if (!res_push && take) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== hw/rtl/vdhp_back.sv =====
// Back part: video memory, access address, control registers and result build.
module vdhp_back import vdhp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       cmd_valid,
	input  cmd_t       cmd,
	output logic       cmd_take,
	input  logic       res_full,
	output logic       res_push,
	output result_t    res,
	output back_stat_t stat
);

	// Video memory
	logic [7:0]         mem [VRAM_DEPTH];
	logic [7:0]         mem_rdata_q;
	logic               mem_we;
	logic [VRAM_AW-1:0] mem_waddr;
	logic [7:0]         mem_wdata;
	logic               mem_re;
	logic [VRAM_AW-1:0] mem_raddr;

	// Sequencer
	bk_state_t          state_q;
	bk_state_t          state_d;
	logic [VRAM_AW-1:0] clr_q;

	// Architectural state
	logic [VRAM_AW-1:0] addr_q, addr_d;
	logic [7:0]         ra_q, ra_d;
	logic               ra_we;
	logic               lv_q, lv_d;
	logic [7:0]         latch_q, latch_d;
	logic [7:0]         regs_q [8];
	logic               reg_we;
	logic [7:0]         status_q, status_d;
	logic               int_q, int_d;
	logic [2:0]         mode_q, mode_d;
	logic [BASE_W-1:0]  bases_q [NBASES];
	logic [BASE_W-1:0]  bases_d [NBASES];
	logic [IMASK_W-1:0] masks_q [NMASKS];
	logic [IMASK_W-1:0] masks_d [NMASKS];
	logic [7:0]         rd_q, rd_d;
	logic               fill_q;

	// Decode helpers
	logic [BASE_W-1:0]  m14;
	logic [VRAM_AW-1:0] amsk;
	logic [VRAM_AW-1:0] addr_cur;
	logic [VRAM_AW-1:0] addr_inc;
	logic [15:0]        ctl_word;
	logic [VRAM_AW-1:0] ctl_addr;
	logic [2:0]         ri;
	logic [7:0]         wv;
	logic [7:0]         old;
	logic [7:0]         r0, r1, r3, r4;

	assign m14      = size_mask(cfg.vram_bits);
	assign amsk     = m14[VRAM_AW-1:0];
	assign addr_cur = addr_q & amsk;
	assign addr_inc = (addr_q + 1'b1) & amsk;
	assign ctl_word = {cmd.data, latch_q};
	assign ctl_addr = ctl_word[VRAM_AW-1:0] & amsk;
	assign ri       = cmd.data[2:0];
	assign wv       = latch_q & REG_MASK[ri];
	assign old      = regs_q[ri];
	assign r0       = regs_q[REG_MODE0];
	assign r1       = regs_q[REG_MODE1];
	assign r3       = regs_q[REG_COLOUR];
	assign r4       = regs_q[REG_PATTERN];

	assign stat.clearing = (state_q == BK_CLEAR);
	assign cmd_take      = (state_q == BK_EXEC) && cmd_valid && !res_full;
	assign res_push      = (state_q == BK_FIN);

	// Sequence the clearing pass, then execute and finish each command
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_CLEAR: if (clr_q == VRAM_AW'(VRAM_DEPTH - 1)) state_d = BK_EXEC;
			BK_EXEC:  if (cmd_take) state_d = BK_FIN;
			BK_FIN:   state_d = BK_EXEC;
			default:  state_d = BK_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_CLEAR) clr_q <= clr_q + 1'b1;
		end
	end

	// Work out the effect of the command at the queue head
	always_comb begin
		addr_d   = addr_q;
		ra_d     = cmd.data;
		ra_we    = 1'b0;
		lv_d     = lv_q;
		latch_d  = latch_q;
		reg_we   = 1'b0;
		status_d = status_q;
		int_d    = int_q;
		mode_d   = mode_q;
		bases_d  = bases_q;
		masks_d  = masks_q;
		rd_d     = 8'd0;
		mem_we   = 1'b0;
		mem_waddr = addr_cur;
		mem_wdata = cmd.data;
		mem_re   = 1'b0;
		mem_raddr = addr_cur;
		case (cmd.op)
			OP_MEM_RD: begin
				rd_d   = ra_q;
				mem_re = 1'b1;
				addr_d = addr_inc;
				lv_d   = 1'b0;
			end
			OP_MEM_WR: begin
				mem_we = 1'b1;
				addr_d = addr_inc;
				ra_we  = 1'b1;
				lv_d   = 1'b0;
			end
			OP_STAT: begin
				rd_d     = status_q;
				status_d = status_q & ST_KEEP;
				int_d    = 1'b0;
				lv_d     = 1'b0;
			end
			OP_CTRL: begin
				if (!lv_q) begin
					latch_d = cmd.data;
					lv_d    = 1'b1;
				end else begin
					lv_d = 1'b0;
					if (cmd.data[7]) begin
						// Register write, dropped when the value is unchanged
						if (wv != old) begin
							reg_we = 1'b1;
							case (ri)
								REG_MODE0: begin
									if (wv[1] ^ old[1]) begin
										if (wv[1]) begin
											bases_d[BASE_COLOUR]  = {r3[7], 13'd0} & m14;
											masks_d[MASK_COLOUR]  = {r3[6:0], 3'b111};
											bases_d[BASE_PATTERN] = {r4[2], 13'd0} & m14;
											masks_d[MASK_PATTERN] = {r4[1:0], r3[4:0], 3'b111};
										end else begin
											bases_d[BASE_COLOUR]  = {r3, 6'd0} & m14;
											bases_d[BASE_PATTERN] = {r4[2:0], 11'd0} & m14;
										end
										mode_d = {r1[3], cfg.bitmap_bit & wv[1], r1[4]};
									end
								end
								REG_MODE1: begin
									int_d  = wv[5] && status_q[7];
									mode_d = {wv[3], cfg.bitmap_bit & r0[1], wv[4]};
								end
								REG_NAME: bases_d[BASE_NAME] = {wv[3:0], 10'd0} & m14;
								REG_COLOUR: begin
									if (r0[1]) begin
										bases_d[BASE_COLOUR] = {wv[7], 13'd0} & m14;
										masks_d[MASK_COLOUR] = {wv[6:0], 3'b111};
									end else begin
										bases_d[BASE_COLOUR] = {wv, 6'd0} & m14;
									end
								end
								REG_PATTERN: begin
									if (r0[1]) begin
										bases_d[BASE_PATTERN] = {wv[2], 13'd0} & m14;
										masks_d[MASK_PATTERN] = {wv[1:0], 8'hff};
									end else begin
										bases_d[BASE_PATTERN] = {wv[2:0], 11'd0} & m14;
									end
								end
								REG_SATTR: bases_d[BASE_SATTR] = {wv[6:0], 7'd0} & m14;
								REG_SPAT:  bases_d[BASE_SPAT]  = {wv[2:0], 11'd0} & m14;
								default: ;
							endcase
						end
					end else begin
						// Address set, with a read-ahead unless the write bit is set
						addr_d = ctl_addr;
						if (!cmd.data[6]) begin
							mem_re    = 1'b1;
							mem_raddr = ctl_addr;
							addr_d    = (ctl_addr + 1'b1) & amsk;
						end
					end
				end
			end
			OP_FRAME: begin
				status_d = status_q | ST_FRAME;
				int_d    = r1[5];
			end
			default: ;
		endcase
	end

	// Memory write and registered read; the clearing pass owns the write port
	always_ff @(posedge clk) begin
		if (state_q == BK_CLEAR) mem[clr_q] <= 8'd0;
		else if (cmd_take && mem_we) mem[mem_waddr] <= mem_wdata;
	end

	always_ff @(posedge clk) begin
		if (cmd_take && mem_re) mem_rdata_q <= mem[mem_raddr];
	end

	// Hold the result byte of the command in flight
	always_ff @(posedge clk) begin
		if (cmd_take) rd_q <= rd_d;
	end

	// Update architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q   <= '0;
			ra_q     <= '0;
			lv_q     <= 1'b0;
			latch_q  <= '0;
			status_q <= '0;
			int_q    <= 1'b0;
			mode_q   <= '0;
			fill_q   <= 1'b0;
			for (int i = 0; i < 8; i++) regs_q[i] <= '0;
			for (int i = 0; i < NBASES; i++) bases_q[i] <= '0;
			for (int i = 0; i < NMASKS; i++) masks_q[i] <= '0;
		end else begin
			if (cmd_take) begin
				addr_q   <= addr_d;
				lv_q     <= lv_d;
				latch_q  <= latch_d;
				status_q <= status_d;
				int_q    <= int_d;
				mode_q   <= mode_d;
				fill_q   <= mem_re;
				bases_q  <= bases_d;
				masks_q  <= masks_d;
				if (ra_we) ra_q <= ra_d;
				if (reg_we) regs_q[ri] <= wv;
			end else if (state_q == BK_FIN) begin
				fill_q <= 1'b0;
				if (fill_q) ra_q <= mem_rdata_q;
			end
		end
	end

	// Build the result word from the updated state
	always_comb begin
		res.read_data           = rd_q;
		res.int_line            = int_q;
		res.display_mode        = mode_q;
		res.display_enable      = regs_q[REG_MODE1][6];
		res.backdrop_colour     = (regs_q[REG_BACKDROP][3:0] == 4'd0) ?
		                          4'd1 : regs_q[REG_BACKDROP][3:0];
		res.name_base           = bases_q[BASE_NAME];
		res.pattern_base        = bases_q[BASE_PATTERN];
		res.colour_base         = bases_q[BASE_COLOUR];
		res.pattern_mask        = masks_q[MASK_PATTERN];
		res.colour_mask         = masks_q[MASK_COLOUR];
		res.sprite_attr_base    = bases_q[BASE_SATTR];
		res.sprite_pattern_base = bases_q[BASE_SPAT];
	end

	// No command is taken while memory is being cleared
	a_no_take_clear: assert property (@(posedge clk) disable iff (!arst_n)
		stat.clearing |-> !cmd_take)
		else $error("command taken during clearing pass");

	// Every taken command yields one result next cycle, with no overlap
	a_take_push: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |=> (res_push && !cmd_take))
		else $error("taken command did not produce a result");

	// Results are only pushed into a queue with room
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into full queue");

	// A memory access or a status read drops the first byte of the latch
	a_latch_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_take && (cmd.op == OP_MEM_RD || cmd.op == OP_MEM_WR || cmd.op == OP_STAT))
		|=> !lv_q)
		else $error("control latch survived a memory access or status read");

endmodule

// ===== bench/vdhp_monitor.sv =====
// Monitor of the video display host port: predicts each result word and compares it.
module vdhp_monitor import vdhp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic                  full,
	input  logic [2:0]            mode,
	input  logic [7:0]            data_byte,
	input  logic                  empty,
	input  logic                  pop,
	input  result_t               seen,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    errors,
	output int                    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// Register 0 bitmap bit, register 1 interrupt enable bit
	localparam int R0_BITMAP = 1;
	localparam int R1_IRQ_EN = 5;

	// Shadow copy of the host port state
	logic [7:0]         vmem [VRAM_DEPTH];
	logic [BASE_W-1:0]  addr;
	logic [7:0]         ahead;
	logic [7:0]         latch;
	logic               latched;
	logic [7:0]         regs [8];
	logic [7:0]         status;
	logic               irq;
	logic [2:0]         scr_mode;
	logic [BASE_W-1:0]  bases [NBASES];
	logic [IMASK_W-1:0] imasks [NMASKS];
	logic [3:0]         vram_bits;
	logic               bitmap_bit;

	result_t expected_words [$];

	// Address mask for the installed memory size
	function automatic logic [BASE_W-1:0] addr_mask();
		int unsigned b;
		b = vram_bits;
		if (b < VRAM_BITS_MIN) b = VRAM_BITS_MIN;
		if (b > VRAM_BITS_MAX) b = VRAM_BITS_MAX;
		return BASE_W'((1 << b) - 1);
	endfunction

	function automatic logic [2:0] screen_mode();
		return {regs[REG_MODE1][3], bitmap_bit & regs[REG_MODE0][R0_BITMAP], regs[REG_MODE1][4]};
	endfunction

	// Return the read-ahead byte and fetch the next one
	function automatic logic [7:0] fetch_ahead();
		logic [BASE_W-1:0] msk;
		logic [7:0]        b;
		msk = addr_mask();
		b = ahead;
		ahead = vmem[addr & msk];
		addr = (addr + 1'b1) & msk;
		latched = 1'b0;
		return b;
	endfunction

	// Apply a control register write and refresh what depends on it
	function automatic void write_ctrl_reg(input logic [2:0] idx, input logic [7:0] raw);
		logic [BASE_W-1:0] msk;
		logic [7:0]        v;
		logic [7:0]        prior;
		int unsigned       r3;
		int unsigned       r4;
		msk = addr_mask();
		v = raw & REG_MASK[idx];
		prior = regs[idx];
		if (prior == v) return;
		regs[idx] = v;
		r3 = regs[REG_COLOUR];
		r4 = regs[REG_PATTERN];
		case (idx)
			REG_MODE0: begin
				if (v[R0_BITMAP] != prior[R0_BITMAP]) begin
					if (v[R0_BITMAP]) begin
						bases[BASE_COLOUR] = BASE_W'((r3 & 'h80) * 64) & msk;
						imasks[MASK_COLOUR] = IMASK_W'(((r3 & 'h7f) * 8) | 7);
						bases[BASE_PATTERN] = BASE_W'((r4 & 4) * 2048) & msk;
						imasks[MASK_PATTERN] = IMASK_W'(((r4 & 3) * 256) | (imasks[MASK_COLOUR] & 255));
					end else begin
						bases[BASE_COLOUR] = BASE_W'(r3 * 64) & msk;
						bases[BASE_PATTERN] = BASE_W'(r4 * 2048) & msk;
					end
					scr_mode = screen_mode();
				end
			end
			REG_MODE1: begin
				irq = v[R1_IRQ_EN] && (status & ST_FRAME) != 0;
				scr_mode = screen_mode();
			end
			REG_NAME: bases[BASE_NAME] = BASE_W'(v * 1024) & msk;
			REG_COLOUR: begin
				if (regs[REG_MODE0][R0_BITMAP]) begin
					bases[BASE_COLOUR] = BASE_W'((r3 & 'h80) * 64) & msk;
					imasks[MASK_COLOUR] = IMASK_W'(((r3 & 'h7f) * 8) | 7);
				end else begin
					bases[BASE_COLOUR] = BASE_W'(r3 * 64) & msk;
				end
			end
			REG_PATTERN: begin
				if (regs[REG_MODE0][R0_BITMAP]) begin
					bases[BASE_PATTERN] = BASE_W'((r4 & 4) * 2048) & msk;
					imasks[MASK_PATTERN] = IMASK_W'(((r4 & 3) * 256) | 255);
				end else begin
					bases[BASE_PATTERN] = BASE_W'(r4 * 2048) & msk;
				end
			end
			REG_SATTR: bases[BASE_SATTR] = BASE_W'(v * 128) & msk;
			REG_SPAT: bases[BASE_SPAT] = BASE_W'(v * 2048) & msk;
			default: ;
		endcase
	endfunction

	// Execute one host access on the shadow state and build its result word
	function automatic result_t predict_access(input logic [2:0] code, input logic [7:0] d);
		result_t           w;
		logic [BASE_W-1:0] msk;
		logic [7:0]        rd;
		msk = addr_mask();
		rd = '0;
		case (code)
			MODE_MEM_RD: rd = fetch_ahead();
			MODE_MEM_WR: begin
				vmem[addr & msk] = d;
				addr = (addr + 1'b1) & msk;
				ahead = d;
				latched = 1'b0;
			end
			MODE_STAT: begin
				rd = status;
				status = status & ST_KEEP;
				irq = 1'b0;
				latched = 1'b0;
			end
			MODE_CTRL: begin
				if (latched) begin
					if (d[7]) begin
						write_ctrl_reg(d[2:0], latch);
					end else begin
						addr = {d[5:0], latch} & msk;
						if (!d[6]) void'(fetch_ahead());
					end
					latched = 1'b0;
				end else begin
					latch = d;
					latched = 1'b1;
				end
			end
			MODE_FRAME: begin
				status = status | ST_FRAME;
				irq = regs[REG_MODE1][R1_IRQ_EN];
			end
			default: ;
		endcase
		w.read_data = rd;
		w.int_line = irq;
		w.display_mode = scr_mode;
		w.display_enable = regs[REG_MODE1][6];
		w.backdrop_colour = (regs[REG_BACKDROP][3:0] == 4'd0) ? 4'd1 : regs[REG_BACKDROP][3:0];
		w.name_base = bases[BASE_NAME];
		w.pattern_base = bases[BASE_PATTERN];
		w.colour_base = bases[BASE_COLOUR];
		w.pattern_mask = imasks[MASK_PATTERN];
		w.colour_mask = imasks[MASK_COLOUR];
		w.sprite_attr_base = bases[BASE_SATTR];
		w.sprite_pattern_base = bases[BASE_SPAT];
		return w;
	endfunction

	task automatic check_field(input string what, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
			errors++;
		end
	endtask

	// Track config, predict accepted words and compare popped words
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			foreach (vmem[i]) vmem[i] = '0;
			foreach (regs[i]) regs[i] = '0;
			foreach (bases[i]) bases[i] = '0;
			foreach (imasks[i]) imasks[i] = '0;
			addr = '0;
			ahead = '0;
			latch = '0;
			latched = 1'b0;
			status = '0;
			irq = 1'b0;
			scr_mode = '0;
			vram_bits = VRAM_BITS_RESET;
			bitmap_bit = 1'b1;
			expected_words.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_VRAM_BITS: vram_bits = cfg_data[3:0];
					CFG_BITMAP_BIT: bitmap_bit = cfg_data[0];
					default: ;
				endcase
			end
			if (push && !full) expected_words.push_back(predict_access(mode, data_byte));
			if (pop && !empty) begin
				if (expected_words.size() == 0) begin
					$display("%0t: result word with nothing expected, actual read_data 0x%0h",
						$time, seen.read_data);
					errors++;
				end else begin
					want = expected_words.pop_front();
					check_field("read_data", want.read_data, seen.read_data);
					check_field("int_line", want.int_line, seen.int_line);
					check_field("display_mode", want.display_mode, seen.display_mode);
					check_field("display_enable", want.display_enable, seen.display_enable);
					check_field("backdrop_colour", want.backdrop_colour, seen.backdrop_colour);
					check_field("name_base", want.name_base, seen.name_base);
					check_field("pattern_base", want.pattern_base, seen.pattern_base);
					check_field("colour_base", want.colour_base, seen.colour_base);
					check_field("pattern_mask", want.pattern_mask, seen.pattern_mask);
					check_field("colour_mask", want.colour_mask, seen.colour_mask);
					check_field("sprite_attr_base", want.sprite_attr_base, seen.sprite_attr_base);
					check_field("sprite_pattern_base", want.sprite_pattern_base,
						seen.sprite_pattern_base);
				end
			end
			pending = expected_words.size();
		end
	end

endmodule

// ===== bench/tb_video_display_host_port.sv =====
// Testbench top of the video display host port: stimulus, idling, watchdog and verdict.
module tb_video_display_host_port import vdhp_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          PERIOD      = 10;
	localparam int          QUIET_LIMIT = 65536;
	localparam int          PHASE_WORDS = 115;
	localparam int          NPHASES     = 6;
	localparam logic [2:0]  MODE_UNUSED_LAST = 3'd7;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	// Memory size and bitmap bit of each random phase
	localparam logic [3:0] PHASE_BITS [NPHASES] = '{4'd12, 4'd15, 4'd13, 4'd0, 4'd14, 4'd14};
	localparam logic       PHASE_BMP  [NPHASES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};

	// Opening accesses: extreme addresses and data, every access code, mode and mask rules
	localparam logic [10:0] OPENING [26] = '{
		{MODE_MEM_RD, 8'hff},
		{MODE_CTRL, 8'h00}, {MODE_CTRL, 8'h40},
		{MODE_MEM_WR, 8'hff}, {MODE_MEM_WR, 8'h00}, {MODE_MEM_WR, 8'h5a},
		{MODE_CTRL, 8'hff}, {MODE_CTRL, 8'h3f},
		{MODE_MEM_WR, 8'ha5},
		{MODE_MEM_RD, 8'h00}, {MODE_MEM_RD, 8'h00},
		{MODE_CTRL, 8'hff}, {MODE_CTRL, 8'h81},
		{MODE_FRAME, 8'h00},
		{MODE_STAT, 8'h00},
		{MODE_CTRL, 8'h03}, {MODE_CTRL, 8'h80},
		{MODE_CTRL, 8'hff}, {MODE_CTRL, 8'h83},
		{MODE_CTRL, 8'hff}, {MODE_CTRL, 8'h84},
		{MODE_CTRL, 8'hff}, {MODE_CTRL, 8'h84},
		{MODE_CTRL, 8'hf0}, {MODE_CTRL, 8'h87},
		{MODE_UNUSED_LAST, 8'hff}
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  push = 1'b0;
	logic                  full;
	logic [2:0]            mode = '0;
	logic [7:0]            data_byte = '0;
	logic                  empty;
	logic                  pop = 1'b0;
	logic [7:0]            read_data;
	logic                  int_line;
	logic [2:0]            display_mode;
	logic                  display_enable;
	logic [3:0]            backdrop_colour;
	logic [BASE_W-1:0]     name_base;
	logic [BASE_W-1:0]     pattern_base;
	logic [BASE_W-1:0]     colour_base;
	logic [IMASK_W-1:0]    pattern_mask;
	logic [IMASK_W-1:0]    colour_mask;
	logic [BASE_W-1:0]     sprite_attr_base;
	logic [BASE_W-1:0]     sprite_pattern_base;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	result_t     seen;
	int          errors;
	int          pending;
	int unsigned sent = 0;
	int unsigned quiet = 0;
	bit          steady = 1'b0;

	always #(PERIOD / 2) clk = ~clk;

	video_display_host_port u_dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.push                (push),
		.full                (full),
		.mode                (mode),
		.data_byte           (data_byte),
		.empty               (empty),
		.pop                 (pop),
		.read_data           (read_data),
		.int_line            (int_line),
		.display_mode        (display_mode),
		.display_enable      (display_enable),
		.backdrop_colour     (backdrop_colour),
		.name_base           (name_base),
		.pattern_base        (pattern_base),
		.colour_base         (colour_base),
		.pattern_mask        (pattern_mask),
		.colour_mask         (colour_mask),
		.sprite_attr_base    (sprite_attr_base),
		.sprite_pattern_base (sprite_pattern_base),
		.cfg_valid           (cfg_valid),
		.cfg_ready           (cfg_ready),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data)
	);

	assign seen = {read_data, int_line, display_mode, display_enable, backdrop_colour,
		name_base, pattern_base, colour_base, pattern_mask, colour_mask,
		sprite_attr_base, sprite_pattern_base};

	vdhp_monitor u_monitor (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.mode      (mode),
		.data_byte (data_byte),
		.empty     (empty),
		.pop       (pop),
		.seen      (seen),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	// Idle length: mostly none or short, now and then long
	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Offer one word and hold it until accepted
	task automatic send(input logic [2:0] code, input logic [7:0] d);
		int unsigned g;
		g = steady ? 0 : gap_len();
		if (g != 0) begin
			push <= 1'b0;
			repeat (g) @(posedge clk);
		end
		push <= 1'b1;
		mode <= code;
		data_byte <= d;
		do @(posedge clk); while (full);
		sent++;
	endtask

	// Stop offering and wait until every expected word has come back
	task automatic drain();
		push <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Write both config registers, optionally also the unused index
	task automatic set_config(input logic [3:0] bits, input logic bmp, input bit poke_unused);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_VRAM_BITS;
		cfg_data <= bits;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= CFG_BITMAP_BIT;
		cfg_data <= {3'($urandom), bmp};
		do @(posedge clk); while (!cfg_ready);
		if (poke_unused) begin
			cfg_index <= CFG_UNUSED;
			cfg_data <= 4'($urandom);
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	// One host sequence: mostly well formed, some noise and broken pairs
	task automatic random_sequence();
		int unsigned pick;
		int unsigned n;
		pick = $urandom_range(0, 99);
		n = $urandom_range(1, 6);
		if (pick < 25) begin
			send(MODE_CTRL, 8'($urandom));
			send(MODE_CTRL, {1'b1, 4'($urandom), 3'($urandom)});
		end else if (pick < 40) begin
			send(MODE_CTRL, 8'($urandom));
			send(MODE_CTRL, {1'b0, 1'($urandom),
				($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 1))});
		end else if (pick < 60) begin
			repeat (n) send(MODE_MEM_WR, 8'($urandom));
		end else if (pick < 78) begin
			repeat (n) send(MODE_MEM_RD, 8'($urandom));
		end else if (pick < 86) begin
			send(MODE_STAT, 8'($urandom));
		end else if (pick < 93) begin
			send(MODE_FRAME, 8'($urandom));
		end else if (pick < 97) begin
			send(MODE_CTRL, 8'($urandom));
		end else begin
			send(3'($urandom_range(MODE_FRAME + 1, MODE_UNUSED_LAST)), 8'($urandom));
		end
	endtask

	// Result side: pop in runs, stall in random gaps
	initial begin
		int unsigned hold;
		int unsigned g;
		@(posedge clk);
		forever begin
			hold = ($urandom_range(0, 99) < 10) ? $urandom_range(50, 150) : $urandom_range(1, 12);
			pop <= 1'b1;
			repeat (hold) @(posedge clk);
			g = gap_len();
			if (g != 0) begin
				pop <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet == QUIET_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// Stimulus and verdict
	initial begin
		int unsigned target;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		foreach (OPENING[i]) send(OPENING[i][10:8], OPENING[i][7:0]);
		drain();
		for (int p = 0; p < NPHASES; p++) begin
			set_config(PHASE_BITS[p], PHASE_BMP[p], p == 3);
			steady = (p % 3 == 1);
			target = sent + PHASE_WORDS;
			while (sent < target) random_sequence();
			drain();
		end
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/vdhp_pkg.sv
hw/rtl/vdhp_front.sv
hw/rtl/vdhp_out_queue.sv
hw/rtl/vdhp_back.sv
hw/rtl/video_display_host_port.sv
bench/vdhp_monitor.sv
bench/tb_video_display_host_port.sv
